FILE: hw/rtl/lru_tbl_pkg.sv
package lru_tbl_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int KEY_BITS    = 64;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int LEN_W       = 24;
   localparam int CAP_W       = 8;
   localparam int KEY_OUT_W   = 64;
   localparam int SLOT_OUT_W  = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_code_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [KEY_OUT_W-1:0]  key;
      logic [LEN_W-1:0]      length;
   } req_payload_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic [LEN_W-1:0]      stored_length;
      logic                  evicted;
      logic [KEY_OUT_W-1:0]  evicted_key;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic select;
      logic read;
      logic update;
   } dp_cmd_type;

   // One-hot (or empty) vector to slot number.
   function automatic logic [SLOT_W-1:0] onehot_to_slot(input logic [MAX_ENTRIES-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (vec[i]) idx = idx | SLOT_W'(i);
      end
      return idx;
   endfunction

endpackage

FILE: hw/rtl/lru_tbl_ctrl.sv
module lru_tbl_ctrl
   import lru_tbl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_COMPARE, ST_SELECT, ST_READ, ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_COMPARE;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_COMPARE: state_ff <= ST_SELECT;
            ST_SELECT:  state_ff <= ST_READ;
            ST_READ: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_ready) state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd.load    = req_ready_ff && req_valid;
      dp_cmd.compare = (state_ff == ST_COMPARE);
      dp_cmd.select  = (state_ff == ST_SELECT);
      dp_cmd.read    = (state_ff == ST_READ);
      dp_cmd.update  = (state_ff == ST_UPDATE);
   end

endmodule

FILE: hw/rtl/lru_tbl_datapath.sv
module lru_tbl_datapath
   import lru_tbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  dp_cmd_type       dp_cmd,
   input  req_payload_type  req_payload,
   output rsp_payload_type  rsp_payload
);

   localparam int CMPW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int MEMW = KEY_BITS + LEN_W;

   logic [CAP_W-1:0]    capacity_ff;
   logic [1:0]          cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [LEN_W-1:0]    len_ff;

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [KEY_BITS-1:0]    key_cell_ff [MAX_ENTRIES];
   logic [SLOT_W-1:0]      rank_ff     [MAX_ENTRIES];
   logic [CNT_W-1:0]       count_ff;

   logic [MAX_ENTRIES-1:0] match_ff;
   logic [MAX_ENTRIES-1:0] victim_ff;
   logic [MAX_ENTRIES-1:0] lowest_ff;
   logic                   evict_need_ff;

   logic                   hit_ff;
   logic                   evict_ff;
   logic                   place_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SLOT_W-1:0]      r_ff;

   logic [MEMW-1:0]        mem [MAX_ENTRIES];
   logic [MEMW-1:0]        rd_ff;
   rsp_payload_type        rsp_ff;
   rsp_payload_type        rsp_in;

   logic [MAX_ENTRIES-1:0] free_vec;
   logic [CNT_W-1:0]       cnt_m1;
   logic [CMPW-1:0]        cap_eff;
   logic [CMPW-1:0]        cnt_ext;
   logic                   any_hit;
   logic [SLOT_W-1:0]      r_sel;

   assign free_vec = ~valid_ff;
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_ext  = CMPW'(count_ff);
   assign cap_eff  = (capacity_ff == '0) ? CMPW'(1) : CMPW'(capacity_ff);
   assign any_hit  = |match_ff;

   always_comb begin
      r_sel = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match_ff[i]) r_sel = r_sel | rank_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_payload.cmd;
         key_ff <= req_payload.key[KEY_BITS-1:0];
         len_ff <= req_payload.length;
      end
      if (dp_cmd.compare) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_ff[i]  <= valid_ff[i] && (key_cell_ff[i] == key_ff);
            victim_ff[i] <= valid_ff[i] && (rank_ff[i] == cnt_m1[SLOT_W-1:0]);
         end
         lowest_ff     <= free_vec & (~free_vec + MAX_ENTRIES'(1));
         evict_need_ff <= (cnt_ext >= cap_eff) || (cnt_ext >= CMPW'(MAX_ENTRIES));
      end
      if (dp_cmd.select) begin
         hit_ff   <= any_hit;
         r_ff     <= r_sel;
         if (cmd_ff == CMD_ADD && !any_hit) begin
            place_ff <= 1'b1;
            evict_ff <= evict_need_ff;
            slot_ff  <= evict_need_ff ? onehot_to_slot(victim_ff)
                                      : onehot_to_slot(lowest_ff);
         end else begin
            place_ff <= 1'b0;
            evict_ff <= 1'b0;
            slot_ff  <= onehot_to_slot(match_ff);
         end
      end
      if (dp_cmd.read) begin
         rd_ff <= mem[slot_ff];
      end
      if (dp_cmd.update && place_ff) begin
         mem[slot_ff] <= {key_ff, len_ff};
      end
   end

   // entry state update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (dp_cmd.update) begin
         unique case (cmd_ff)
            CMD_FIND, CMD_ADD: begin
               if (hit_ff) begin
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (valid_ff[i] && rank_ff[i] < r_ff) rank_ff[i] <= rank_ff[i] + 1'b1;
                  end
                  rank_ff[slot_ff] <= '0;
               end else if (place_ff) begin
                  // age every other entry; the new one becomes most recent
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (valid_ff[i] && SLOT_W'(i) != slot_ff) begin
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                     end
                  end
                  rank_ff[slot_ff]     <= '0;
                  valid_ff[slot_ff]    <= 1'b1;
                  key_cell_ff[slot_ff] <= key_ff;
                  if (!evict_ff) count_ff <= count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (hit_ff) begin
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (valid_ff[i] && rank_ff[i] > r_ff) rank_ff[i] <= rank_ff[i] - 1'b1;
                  end
                  valid_ff[slot_ff] <= 1'b0;
                  count_ff          <= count_ff - CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd_ff != CMD_NONE && hit_ff) begin
         rsp_in.hit           = 1'b1;
         rsp_in.slot          = SLOT_OUT_W'(slot_ff);
         rsp_in.stored_length = rd_ff[LEN_W-1:0];
      end else if (place_ff) begin
         rsp_in.slot = SLOT_OUT_W'(slot_ff);
         if (evict_ff) begin
            rsp_in.evicted     = 1'b1;
            rsp_in.evicted_key = KEY_OUT_W'(rd_ff[MEMW-1:LEN_W]);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (dp_cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/lru_keyed_entry_table.sv
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  req_payload (cmd, key, length)
// rsp      out  rsp_valid/rsp_ready  rsp_payload (hit, slot, stored_length, evicted, evicted_key)
// csr      in   csr_wr_en            csr_wr_data (capacity)
//
// After acceptance the block compares all key cells, selects the slot, reads the
// length/key memory, then updates ranks and state and registers the result.
// The next item can be taken in the same cycle that the result becomes valid.
// One item at a time; the next item is taken while the result still waits.
// A stalled result holds the item before its update until rsp_ready frees it.
// Synchronous reset clears valid bits and entry count and sets capacity to 100.
module lru_keyed_entry_table
   import lru_tbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   dp_cmd_type dp_cmd;

   lru_tbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   lru_tbl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.hit && rsp_payload.evicted))
      else $error("hit and eviction in one result");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.evicted |-> rsp_payload.evicted_key == '0)
      else $error("evicted key without eviction");

   a_miss_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |-> rsp_payload.stored_length == '0)
      else $error("stored length on a miss");

endmodule
